[sv/zph_pkg.sv]
package zph_pkg;

	localparam int unsigned SQUARES     = 64;
	localparam int unsigned LANES       = 8;
	localparam int unsigned SQ_PER_LANE = SQUARES / LANES;
	localparam int unsigned PIECES      = 6;
	localparam int unsigned KINDS       = 2 * PIECES;
	localparam int unsigned KIND_W      = $clog2(KINDS);
	localparam int unsigned FIFO_DEPTH  = 3;
	localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	// key table layout
	localparam int unsigned KEY_SIDE   = 768;
	localparam int unsigned KEY_CASTLE = 769;
	localparam int unsigned KEY_EP     = 773;

	localparam logic [63:0] SEED   = 64'h00C0_FFEE_5EED_5BAD;
	localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX1   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX2   = 64'h94D0_49BB_1331_11EB;

	localparam logic [63:0] FILE_A = 64'h0101_0101_0101_0101;
	localparam logic [63:0] FILE_H = 64'h8080_8080_8080_8080;

	typedef logic [63:0] key_t;
	typedef key_t [KINDS-1:0] sq_keys_t;
	typedef sq_keys_t [SQ_PER_LANE-1:0] lane_keys_t;
	typedef key_t [LANES-1:0] part_vec_t;

	// splitmix64 output number idx, evaluated at elaboration only
	function automatic key_t key_at(input int unsigned idx);
		logic [63:0] s;
		logic [63:0] z;
		s = SEED + GOLDEN * 64'(idx + 1);
		z = (s ^ (s >> 30)) * MIX1;
		z = (z ^ (z >> 27)) * MIX2;
		return z ^ (z >> 31);
	endfunction

	localparam key_t SIDE_KEY = key_at(KEY_SIDE);
	localparam key_t [3:0] CASTLE_KEYS = {
		key_at(KEY_CASTLE + 3), key_at(KEY_CASTLE + 2),
		key_at(KEY_CASTLE + 1), key_at(KEY_CASTLE)
	};
	localparam key_t [7:0] EP_KEYS = {
		key_at(KEY_EP + 7), key_at(KEY_EP + 6), key_at(KEY_EP + 5), key_at(KEY_EP + 4),
		key_at(KEY_EP + 3), key_at(KEY_EP + 2), key_at(KEY_EP + 1), key_at(KEY_EP)
	};

	// per-item control carried alongside the lane partials
	typedef struct packed {
		logic        valid;
		logic        last;
		logic        black;
		logic [3:0]  castle;
		logic [2:0]  ep_file;
		logic        pawn_w;
		logic        pawn_b;
		logic [63:0] ep_from;  // squares a capturing pawn would stand on
		logic [63:0] occ;
	} ctl_t;

endpackage

[sv/zph_lane.sv]
module zph_lane (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           kind_ok,
	input  logic [zph_pkg::KIND_W-1:0]     kind,
	input  logic [zph_pkg::SQ_PER_LANE-1:0] occ,
	input  zph_pkg::lane_keys_t            keys,
	output zph_pkg::key_t                  part_s1
);

	zph_pkg::key_t x;

	always_comb begin
		x = '0;
		for (int j = 0; j < zph_pkg::SQ_PER_LANE; j++) begin
			if (kind_ok && occ[j]) begin
				x = x ^ keys[j][kind];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s1 <= x;
		end
	end

endmodule

[sv/zph_merge.sv]
module zph_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  zph_pkg::ctl_t     ctl_in,
	input  zph_pkg::part_vec_t part_s1,
	output logic              push,
	output zph_pkg::key_t     push_data,
	output logic              pend
);

	zph_pkg::ctl_t ctl_s1;
	zph_pkg::key_t acc_q;
	logic [63:0]   pawn_w_q;
	logic [63:0]   pawn_b_q;

	zph_pkg::key_t acc_n;
	logic [63:0]   pawn_w_n;
	logic [63:0]   pawn_b_n;
	logic          capture;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_comb begin
		zph_pkg::key_t x;
		x = '0;
		for (int l = 0; l < zph_pkg::LANES; l++) begin
			x = x ^ part_s1[l];
		end
		acc_n = acc_q ^ x;
	end

	assign pawn_w_n = pawn_w_q | (ctl_s1.pawn_w ? ctl_s1.occ : '0);
	assign pawn_b_n = pawn_b_q | (ctl_s1.pawn_b ? ctl_s1.occ : '0);
	assign capture  = |(ctl_s1.ep_from & (ctl_s1.black ? pawn_b_n : pawn_w_n));

	always_comb begin
		zph_pkg::key_t h;
		h = acc_n;
		if (ctl_s1.black) begin
			h = h ^ zph_pkg::SIDE_KEY;
		end
		for (int i = 0; i < 4; i++) begin
			if (ctl_s1.castle[i]) begin
				h = h ^ zph_pkg::CASTLE_KEYS[i];
			end
		end
		if (capture) begin
			h = h ^ zph_pkg::EP_KEYS[ctl_s1.ep_file];
		end
		push_data = h;
	end

	assign push = ctl_s1.valid && ctl_s1.last;
	assign pend = push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pawn_w_q <= '0;
			pawn_b_q <= '0;
		end else if (ctl_s1.valid) begin
			if (ctl_s1.last) begin
				acc_q    <= '0;
				pawn_w_q <= '0;
				pawn_b_q <= '0;
			end else begin
				acc_q    <= acc_n;
				pawn_w_q <= pawn_w_n;
				pawn_b_q <= pawn_b_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (acc_q == '0 && pawn_w_q == '0 && pawn_b_q == '0))
		else $error("position state not cleared after finish");
	a_push_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> $past(ctl_in.valid && ctl_in.last))
		else $error("hash pushed without a matching last item");
`endif

endmodule

[sv/zph_out_fifo.sv]
module zph_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  zph_pkg::key_t                   push_data,
	input  logic                            pop_ready,
	output logic                            out_valid,
	output zph_pkg::key_t                   out_data,
	output logic [zph_pkg::FIFO_CNT_W-1:0]  count
);

	zph_pkg::key_t                  mem [zph_pkg::FIFO_DEPTH];
	logic [zph_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [zph_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [zph_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                           pop;

	function automatic logic [zph_pkg::FIFO_PTR_W-1:0] ptr_next(
		input logic [zph_pkg::FIFO_PTR_W-1:0] p);
		if (p == zph_pkg::FIFO_PTR_W'(zph_pkg::FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[rd_q];
	assign pop       = out_valid && pop_ready;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != zph_pkg::FIFO_CNT_W'(zph_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");
`endif

endmodule

[sv/chess_position_zobrist_hash.sv]
// Zobrist hash of a chess position, fed one bitboard item at a time.
// Slave channel: one item per bitboard (colour and piece kind in s_tuser,
// occupancy plus the position flags in s_tdata); s_tlast marks the final
// bitboard of a position. Side to move, castling and en-passant fields are
// only looked at on that final item. Piece kinds six and seven are ignored.
// Master channel: one 64-bit hash item per position, nothing for other items.
// Eight lanes each XOR the keys of eight squares in parallel; a merge stage
// folds the lane results into the accumulator and, on the last item, adds
// the side, castling and en-passant keys.
// Lane and control registers, then the result queue, lie between a last item
// and m_tvalid. Throughput: one item per cycle while s_tready is high.
// A three-deep result queue lets the input keep flowing while the receiver
// stalls; s_tready drops only once queued plus in-flight hashes fill it.
// Reset clears the accumulator, both pawn sets, the merge control stage and the queue.
module chess_position_zobrist_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [63:0] occupancy, [64] black_to_move, [68:65] castle_rights,
	// [69] ep_present, [75:70] ep_target, [79:76] zero
	input  logic [79:0] s_tdata,
	// [0] colour, [3:1] piece
	input  logic [3:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [63:0] hash_key
	output logic [63:0] m_tdata
);

	logic                            accept;
	logic                            colour;
	logic [2:0]                      piece;
	logic [63:0]                     occ;
	logic [5:0]                      ep_sq;
	logic [63:0]                     ep_bit;
	logic                            kind_ok;
	logic [zph_pkg::KIND_W-1:0]      kind;
	zph_pkg::ctl_t                   ctl_in;
	zph_pkg::part_vec_t              part_s1;
	logic                            push;
	zph_pkg::key_t                   push_data;
	logic                            pend;
	logic [zph_pkg::FIFO_CNT_W-1:0]  count;

	assign colour = s_tuser[0];
	assign piece  = s_tuser[3:1];
	assign occ    = s_tdata[63:0];
	assign ep_sq  = s_tdata[75:70];

	// Only registered terms: room for every hash that could still arrive.
	assign s_tready = ({1'b0, count} + {{zph_pkg::FIFO_CNT_W{1'b0}}, pend})
		< (zph_pkg::FIFO_CNT_W + 1)'(zph_pkg::FIFO_DEPTH);
	assign accept = s_tvalid && s_tready;

	// key block index: colour*6 + piece
	assign kind_ok = (piece < 3'(zph_pkg::PIECES));
	assign kind    = kind_ok
		? (zph_pkg::KIND_W'(piece) + (colour ? zph_pkg::KIND_W'(zph_pkg::PIECES) : '0))
		: '0;

	// en-passant target square; the capture squares of the side to move come from it
	assign ep_bit = 64'd1 << ep_sq;

	always_comb begin
		ctl_in.valid   = accept;
		ctl_in.last    = s_tlast;
		ctl_in.black   = s_tdata[64];
		ctl_in.castle  = s_tdata[68:65];
		ctl_in.ep_file = ep_sq[2:0];
		ctl_in.pawn_w  = (piece == 3'd0) && !colour;
		ctl_in.pawn_b  = (piece == 3'd0) && colour;
		ctl_in.occ     = occ;
		if (!s_tdata[69]) begin
			ctl_in.ep_from = '0;
		end else if (!s_tdata[64]) begin
			ctl_in.ep_from = ((ep_bit >> 7) & ~zph_pkg::FILE_A)
				| ((ep_bit >> 9) & ~zph_pkg::FILE_H);
		end else begin
			ctl_in.ep_from = ((ep_bit << 9) & ~zph_pkg::FILE_A)
				| ((ep_bit << 7) & ~zph_pkg::FILE_H);
		end
	end

	for (genvar l = 0; l < zph_pkg::LANES; l++) begin : g_lane
		zph_pkg::lane_keys_t keys;

		for (genvar j = 0; j < zph_pkg::SQ_PER_LANE; j++) begin : g_sq
			for (genvar k = 0; k < zph_pkg::KINDS; k++) begin : g_kind
				localparam zph_pkg::key_t K =
					zph_pkg::key_at(k * zph_pkg::SQUARES + l * zph_pkg::SQ_PER_LANE + j);
				assign keys[j][k] = K;
			end
		end

		zph_lane u_lane (
			.clk     (clk),
			.en      (accept),
			.kind_ok (kind_ok),
			.kind    (kind),
			.occ     (occ[l*zph_pkg::SQ_PER_LANE +: zph_pkg::SQ_PER_LANE]),
			.keys    (keys),
			.part_s1 (part_s1[l])
		);
	end

	zph_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_in),
		.part_s1   (part_s1),
		.push      (push),
		.push_data (push_data),
		.pend      (pend)
	);

	zph_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.count     (count)
	);

`ifndef SYNTHESIS
	a_last_gives_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> ##1 m_tvalid)
		else $error("no hash two cycles after a last item");
	a_nonlast_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast) |=> !push)
		else $error("hash produced for an item that was not last");
`endif

endmodule

[tb/tb_chess_position_zobrist_hash.sv]
module tb_chess_position_zobrist_hash;
	timeunit 1ns;
	timeprecision 1ps;

	// key generator constants (splitmix64)
	localparam bit [63:0] ZOB_SEED   = 64'h00C0_FFEE_5EED_5BAD;
	localparam bit [63:0] ZOB_STEP   = 64'h9E37_79B9_7F4A_7C15;
	localparam bit [63:0] ZOB_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
	localparam bit [63:0] ZOB_MUL_B  = 64'h94D0_49BB_1331_11EB;
	localparam int        NUM_KEYS   = 781;

	localparam bit WHITE = 1'b0;
	localparam bit BLACK = 1'b1;

	// piece kinds; the last two are ignored by the block
	typedef enum bit [2:0] {
		PAWN, KNIGHT, BISHOP, ROOK, QUEEN, KING, NO_KIND6, NO_KIND7
	} piece_e;

	typedef struct {
		bit        colour;
		piece_e    piece;
		bit [63:0] occ;
		bit        btm;
		bit [3:0]  castle;
		bit        ep_present;
		bit [5:0]  ep_sq;
		bit        last;
	} board_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	chess_position_zobrist_hash DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// own copy of the key table and of the hashing state
	bit [63:0] zob_key [NUM_KEYS];
	bit [63:0] run_key;
	bit [63:0] pawns_w;
	bit [63:0] pawns_b;

	bit [63:0] hash_expected_q [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;
	int mismatches;
	int counted_items;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// run guard: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void build_keys();
		bit [63:0] s;
		bit [63:0] z;
		s = ZOB_SEED;
		for (int i = 0; i < NUM_KEYS; i++) begin
			s = s + ZOB_STEP;
			z = s;
			z = (z ^ (z >> 30)) * ZOB_MUL_A;
			z = (z ^ (z >> 27)) * ZOB_MUL_B;
			zob_key[i] = z ^ (z >> 31);
		end
	endfunction

	// Fold one bitboard into the running hash. On the final item of a position,
	// returns 1 with the finished hash and clears the state.
	function automatic bit fold_item(input board_item_t it, output bit [63:0] hash);
		bit [63:0] t;
		bit [63:0] from;
		int        base;
		hash = '0;
		if (it.piece <= KING) begin
			base = int'(it.colour) * 384 + int'(it.piece) * 64;
			for (int sq = 0; sq < 64; sq++)
				if (it.occ[sq])
					run_key ^= zob_key[base + sq];
			if (it.piece == PAWN) begin
				if (it.colour == BLACK)
					pawns_b |= it.occ;
				else
					pawns_w |= it.occ;
			end
		end
		if (!it.last)
			return 1'b0;
		hash = run_key;
		if (it.btm)
			hash ^= zob_key[zph_pkg::KEY_SIDE];
		for (int i = 0; i < 4; i++)
			if (it.castle[i])
				hash ^= zob_key[zph_pkg::KEY_CASTLE + i];
		// squares a capturing pawn of the side to move would stand on,
		// with wrap-around across the a/h files removed
		t = 64'd1 << it.ep_sq;
		if (!it.btm)
			from = (((t >> 7) & ~zph_pkg::FILE_A) | ((t >> 9) & ~zph_pkg::FILE_H)) & pawns_w;
		else
			from = (((t << 9) & ~zph_pkg::FILE_A) | ((t << 7) & ~zph_pkg::FILE_H)) & pawns_b;
		if (it.ep_present && from != '0)
			hash ^= zob_key[zph_pkg::KEY_EP + it.ep_sq[2:0]];
		run_key = '0;
		pawns_w = '0;
		pawns_b = '0;
		return 1'b1;
	endfunction

	function automatic board_item_t mk(input bit colour, input piece_e piece,
			input bit [63:0] occ, input bit btm, input bit [3:0] castle,
			input bit ep_present, input bit [5:0] ep_sq, input bit last);
		board_item_t it;
		it.colour     = colour;
		it.piece      = piece;
		it.occ        = occ;
		it.btm        = btm;
		it.castle     = castle;
		it.ep_present = ep_present;
		it.ep_sq      = ep_sq;
		it.last       = last;
		return it;
	endfunction

	function automatic bit [63:0] rand_board();
		bit [63:0] b;
		b = '0;
		case ($urandom_range(7))
			0: b = '0;
			1: b = '1;
			2, 3: begin
				repeat ($urandom_range(1, 4))
					b[$urandom_range(63)] = 1'b1;
			end
			default: b = {$urandom, $urandom};
		endcase
		return b;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("mismatch @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Offer one item (after any random gap) and wait for it to be taken.
	// Leaves tvalid high at the following falling edge.
	task automatic send_item(input board_item_t it);
		bit [63:0] h;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, it.ep_sq, it.ep_present, it.castle, it.btm, it.occ};
		s_tuser  <= {it.piece, it.colour};
		s_tlast  <= it.last;
		do
			@(posedge clk);
		while (!s_tready);
		if (fold_item(it, h))
			hash_expected_q.push_back(h);
		if (it.piece <= KING || it.last)
			counted_items++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (hash_expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One position: a run of bitboards ending in a last item. The side to move
	// often gets pawns on the squares next to the en-passant target.
	task automatic send_position();
		bit        stm;
		bit [5:0]  ep;
		bit [63:0] cand;
		int        n;
		board_item_t it;
		stm  = 1'($urandom_range(1));
		ep   = stm ? 6'($urandom_range(16, 23)) : 6'($urandom_range(40, 47));
		cand = stm ? ((64'd1 << (ep + 7)) | (64'd1 << (ep + 9)))
		           : ((64'd1 << (ep - 7)) | (64'd1 << (ep - 9)));
		n    = $urandom_range(1, 10);
		for (int k = 0; k < n; k++) begin
			it.colour = 1'($urandom_range(1));
			if ($urandom_range(99) < 8)
				it.piece = piece_e'($urandom_range(6, 7));
			else
				it.piece = piece_e'($urandom_range(5));
			if (k == 0 && $urandom_range(9) < 7) begin
				it.colour = stm;
				it.piece  = PAWN;
			end
			it.occ = rand_board();
			if (it.piece == PAWN && it.colour == stm)
				it.occ |= cand & {$urandom, $urandom};
			it.last = (k == n - 1);
			if (it.last) begin
				it.btm        = stm;
				it.castle     = 4'($urandom_range(15));
				it.ep_present = ($urandom_range(3) != 0);
				it.ep_sq      = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : ep;
			end else begin
				// junk in the position flags, must be ignored
				it.btm        = 1'($urandom_range(1));
				it.castle     = 4'($urandom_range(15));
				it.ep_present = 1'($urandom_range(1));
				it.ep_sq      = 6'($urandom_range(63));
			end
			send_item(it);
		end
	endtask

	task automatic test_directed();
		bit [63:0] r;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// empty position, every field but last zero
		send_item(mk(WHITE, PAWN, '0, 1'b0, 4'h0, 1'b0, 6'd0, 1'b1));
		// full boards; flags on a non-last item are ignored,
		// target on h8 with black to move has no capture square
		send_item(mk(WHITE, PAWN, '1, 1'b1, 4'hF, 1'b1, 6'd63, 1'b0));
		send_item(mk(BLACK, KING, '1, 1'b1, 4'hF, 1'b1, 6'd63, 1'b1));
		// ignored kinds, including on the last item
		send_item(mk(WHITE, NO_KIND6, '1, 1'b0, 4'h0, 1'b0, 6'd0, 1'b0));
		send_item(mk(BLACK, NO_KIND7, '1, 1'b1, 4'h5, 1'b1, 6'd20, 1'b1));
		// every colour and piece kind once
		for (int c = 0; c < 2; c++)
			for (int p = 0; p <= int'(KING); p++)
				send_item(mk(c[0], piece_e'(p), {$urandom, $urandom}, 1'b0, 4'hA,
					1'b1, 6'd44, (c == 1 && p == int'(KING))));
		// same board twice cancels
		r = {$urandom, $urandom};
		send_item(mk(WHITE, QUEEN, r, 1'b0, 4'h0, 1'b0, 6'd0, 1'b0));
		send_item(mk(WHITE, QUEEN, r, 1'b1, 4'h3, 1'b0, 6'd0, 1'b1));
		// white pawn b5 takes on a6
		send_item(mk(WHITE, PAWN, 64'd1 << 33, 1'b0, 4'h0, 1'b0, 6'd0, 1'b0));
		send_item(mk(BLACK, ROOK, 64'd1 << 56, 1'b0, 4'h0, 1'b1, 6'd40, 1'b1));
		// white pawn h4 must not wrap onto a6
		send_item(mk(WHITE, PAWN, 64'd1 << 31, 1'b0, 4'h0, 1'b0, 6'd0, 1'b0));
		send_item(mk(BLACK, KNIGHT, '0, 1'b0, 4'h3, 1'b1, 6'd40, 1'b1));
		// black pawn b4 takes on a3
		send_item(mk(BLACK, PAWN, 64'd1 << 25, 1'b0, 4'h0, 1'b0, 6'd0, 1'b0));
		send_item(mk(WHITE, BISHOP, '0, 1'b1, 4'h0, 1'b1, 6'd16, 1'b1));
		// black pawn a5 must not wrap onto h3
		send_item(mk(BLACK, PAWN, 64'd1 << 32, 1'b0, 4'h0, 1'b0, 6'd0, 1'b0));
		send_item(mk(WHITE, KING, 64'd1 << 4, 1'b1, 4'hC, 1'b1, 6'd23, 1'b1));
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int n_items);
		board_item_t it;
		int target;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = counted_items + n_items;
		while (counted_items < target) begin
			if ($urandom_range(99) < 12) begin
				// noise: anything the fields allow
				it = mk(1'($urandom_range(1)), piece_e'($urandom_range(7)), rand_board(),
					1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
					6'($urandom_range(63)), 1'($urandom_range(1)));
				send_item(it);
			end else begin
				send_position();
			end
		end
		// close any noise run so nothing is left half-folded
		send_item(mk(WHITE, PAWN, '0, 1'b0, 4'h0, 1'b0, 6'd0, 1'b1));
		stop_sending();
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// receiver holds off while single-item positions pile up
		hold_off = 100;
		repeat (30)
			send_item(mk(1'($urandom_range(1)), piece_e'($urandom_range(5)), rand_board(),
				1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
				6'($urandom_range(63)), 1'b1));
		stop_sending();
		wait_drained();
		// sender waits for every hash before the next position
		repeat (4) begin
			send_position();
			stop_sending();
			wait_drained();
		end
	endtask

	// receiver: random stalls, or a counted hold-off when asked for
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// compare each hash with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hash_expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected hash %h", m_tdata));
			end else begin
				if (m_tdata !== hash_expected_q[0])
					report_mismatch($sformatf("hash_key got %h want %h",
						m_tdata, hash_expected_q[0]));
				void'(hash_expected_q.pop_front());
			end
		end
	end

	initial begin
		build_keys();
		run_key        = '0;
		pawns_w        = '0;
		pawns_b        = '0;
		mismatches     = 0;
		counted_items  = 0;
		hold_off       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random_traffic(0, 0, 160);
		test_random_traffic(45, 0, 160);
		test_random_traffic(0, 45, 160);
		test_random_traffic(14, 14, 160);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && hash_expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
